[hdl/smp_pkg.sv]
// shared types and codes of the startup message parser
`default_nettype none

package smp_pkg;

    // result kind
    localparam logic KIND_PAIR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // final status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_VERSION = 3'd1;
    localparam logic [2:0] ST_NO_TERM     = 3'd2;
    localparam logic [2:0] ST_NAME_UNTERM = 3'd3;
    localparam logic [2:0] ST_VALUE_UNTERM = 3'd4;
    localparam logic [2:0] ST_TRAILING    = 3'd5;
    localparam logic [2:0] ST_NO_USER     = 3'd6;
    localparam logic [2:0] ST_BAD_LENGTH  = 3'd7;

    // version word after reset
    localparam logic [31:0] DEFAULT_VERSION = 32'h0003_0000;

    // depth of the event queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // one classified event: a pair record, a status record or both
    typedef struct packed {
        logic        has_pair;
        logic        has_status;
        logic [11:0] name_off;
        logic [11:0] value_off;
        logic [11:0] pair_count;
        logic [2:0]  status;
    } t_evt;

endpackage

`default_nettype wire

[hdl/smp_front.sv]
// byte parser: tracks the message phase and classifies each byte into events
`default_nettype none

module smp_front
    import smp_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_accept,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_first,
    output t_evt             o_evt,
    output logic             o_evt_valid
);

    localparam int IDX_W = $clog2(MAX_MESSAGE_BYTES + 1);

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_HEADER     = 3'd1;
    localparam logic [2:0] PH_NAME_START = 3'd2;
    localparam logic [2:0] PH_IN_NAME    = 3'd3;
    localparam logic [2:0] PH_IN_VALUE   = 3'd4;
    localparam logic [2:0] PH_DONE       = 3'd5;

    logic [31:0]      r_exp_ver;
    logic [2:0]       r_phase, n_phase;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [31:0]      r_len, n_len;
    logic [31:0]      r_ver, n_ver;
    logic [11:0]      r_pairs, n_pairs;
    logic [11:0]      r_name_st, n_name_st;
    logic [11:0]      r_value_st, n_value_st;

    logic [2:0]       cur_phase;
    logic [IDX_W-1:0] cur_idx, idx_inc;
    logic [31:0]      cur_len, cur_ver;
    logic [11:0]      cur_pairs, cur_name_st, cur_value_st;
    logic             at_end;

    // a first byte restarts the parse from a clean state
    assign cur_phase    = i_first ? PH_HEADER : r_phase;
    assign cur_idx      = i_first ? '0 : r_idx;
    assign cur_len      = i_first ? '0 : r_len;
    assign cur_ver      = i_first ? '0 : r_ver;
    assign cur_pairs    = i_first ? '0 : r_pairs;
    assign cur_name_st  = i_first ? '0 : r_name_st;
    assign cur_value_st = i_first ? '0 : r_value_st;

    assign idx_inc = cur_idx + IDX_W'(1);
    assign at_end  = ({{(32 - IDX_W){1'b0}}, idx_inc} == cur_len);

    // phase update and event classification
    always_comb begin
        n_phase     = cur_phase;
        n_idx       = cur_idx;
        n_len       = cur_len;
        n_ver       = cur_ver;
        n_pairs     = cur_pairs;
        n_name_st   = cur_name_st;
        n_value_st  = cur_value_st;
        o_evt_valid = 1'b0;
        o_evt       = '0;
        unique case (cur_phase)
            PH_IDLE, PH_DONE: begin
            end
            PH_HEADER: begin
                if (cur_idx < IDX_W'(4)) begin
                    n_len = {cur_len[23:0], i_data_byte};
                end else begin
                    n_ver = {cur_ver[23:0], i_data_byte};
                end
                n_idx = idx_inc;
                if (idx_inc == IDX_W'(8)) begin
                    priority if (n_ver != r_exp_ver) begin
                        o_evt_valid = 1'b1;
                        o_evt.status = ST_BAD_VERSION;
                    end else if (n_len < 32'd8 || n_len > 32'(MAX_MESSAGE_BYTES)) begin
                        o_evt_valid = 1'b1;
                        o_evt.status = ST_BAD_LENGTH;
                    end else if (n_len == 32'd8) begin
                        o_evt_valid = 1'b1;
                        o_evt.status = ST_NO_TERM;
                    end else begin
                        n_phase = PH_NAME_START;
                    end
                    o_evt.has_status = o_evt_valid;
                    if (o_evt_valid) begin
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_NAME_START: begin
                n_idx = idx_inc;
                if (i_data_byte == 8'd0) begin
                    o_evt_valid = 1'b1;
                    if (!at_end) begin
                        o_evt.status = ST_TRAILING;
                    end else if (cur_pairs == 12'd0) begin
                        o_evt.status = ST_NO_USER;
                    end else begin
                        o_evt.status = ST_OK;
                    end
                end else begin
                    n_name_st = 12'(cur_idx);
                    n_phase   = PH_IN_NAME;
                    if (at_end) begin
                        o_evt_valid  = 1'b1;
                        o_evt.status = ST_NAME_UNTERM;
                    end
                end
                o_evt.has_status = o_evt_valid;
                if (o_evt_valid) begin
                    n_phase = PH_DONE;
                end
            end
            PH_IN_NAME: begin
                n_idx = idx_inc;
                if (i_data_byte == 8'd0) begin
                    n_value_st = 12'(idx_inc);
                    n_phase    = PH_IN_VALUE;
                    if (at_end) begin
                        o_evt_valid  = 1'b1;
                        o_evt.status = ST_VALUE_UNTERM;
                    end
                end else if (at_end) begin
                    o_evt_valid  = 1'b1;
                    o_evt.status = ST_NAME_UNTERM;
                end
                o_evt.has_status = o_evt_valid;
                if (o_evt_valid) begin
                    n_phase = PH_DONE;
                end
            end
            PH_IN_VALUE: begin
                n_idx = idx_inc;
                if (i_data_byte == 8'd0) begin
                    // pair done, and a status too if the message ends here
                    n_pairs          = cur_pairs + 12'd1;
                    o_evt_valid      = 1'b1;
                    o_evt.has_pair   = 1'b1;
                    o_evt.has_status = at_end;
                    o_evt.status     = ST_NO_TERM;
                    n_phase          = at_end ? PH_DONE : PH_NAME_START;
                end else if (at_end) begin
                    o_evt_valid      = 1'b1;
                    o_evt.has_status = 1'b1;
                    o_evt.status     = ST_VALUE_UNTERM;
                    n_phase          = PH_DONE;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
        o_evt.name_off   = cur_name_st;
        o_evt.value_off  = cur_value_st;
        o_evt.pair_count = n_pairs;
        o_evt_valid      = o_evt_valid & i_accept;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ver  <= DEFAULT_VERSION;
            r_phase    <= PH_IDLE;
            r_idx      <= '0;
            r_len      <= '0;
            r_ver      <= '0;
            r_pairs    <= '0;
            r_name_st  <= '0;
            r_value_st <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_exp_ver <= i_cfg_data;
            end
            if (i_accept) begin
                r_phase    <= n_phase;
                r_idx      <= n_idx;
                r_len      <= n_len;
                r_ver      <= n_ver;
                r_pairs    <= n_pairs;
                r_name_st  <= n_name_st;
                r_value_st <= n_value_st;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/smp_queue.sv]
// short event queue between the parser and the result side
`default_nettype none

module smp_queue
    import smp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  wire t_evt i_evt,
    output logic      o_full,
    input  wire logic i_rd,
    output t_evt      o_evt,
    output logic      o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_evt             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = (r_count == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_evt   = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + (PTR_W + 1)'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - (PTR_W + 1)'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PTR_W + 1)'(QUEUE_DEPTH))
        else $error("event queue count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_wr && !do_rd) |=> (r_count == $past(r_count) + (PTR_W + 1)'(1)))
        else $error("event queue count did not follow a write");

endmodule

`default_nettype wire

[hdl/smp_back.sv]
// result side: turns queued events into result words in an output register
`default_nettype none

module smp_back
    import smp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_evt        i_evt,
    input  wire logic        i_evt_empty,
    output logic             o_evt_rd,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic             o_kind,
    output logic [11:0]      o_name_offset,
    output logic [11:0]      o_value_offset,
    output logic [2:0]       o_status,
    output logic [11:0]      o_pair_count,
    output logic             o_last
);

    logic        r_valid;
    logic        r_pend;
    logic [2:0]  r_pend_status;
    logic [11:0] r_pend_count;
    logic        r_kind;
    logic [11:0] r_name_off;
    logic [11:0] r_value_off;
    logic [2:0]  r_status;
    logic [11:0] r_count;
    logic        r_last;
    logic        load;

    // output register is free or its word is taken this cycle
    assign load     = !r_valid || i_pop;
    assign o_evt_rd = load && !r_pend && !i_evt_empty;

    assign o_empty        = !r_valid;
    assign o_kind         = r_kind;
    assign o_name_offset  = r_name_off;
    assign o_value_offset = r_value_off;
    assign o_status       = r_status;
    assign o_pair_count   = r_count;
    assign o_last         = r_last;

    // control: word valid and a status waiting behind a pair word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= !i_evt_empty;
                r_pend  <= !i_evt_empty && i_evt.has_pair && i_evt.has_status;
            end
        end
    end

    // result word payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_kind      <= KIND_STATUS;
                r_name_off  <= '0;
                r_value_off <= '0;
                r_status    <= r_pend_status;
                r_count     <= r_pend_count;
                r_last      <= 1'b1;
            end else if (i_evt.has_pair) begin
                r_kind        <= KIND_PAIR;
                r_name_off    <= i_evt.name_off;
                r_value_off   <= i_evt.value_off;
                r_status      <= ST_OK;
                r_count       <= i_evt.pair_count;
                r_last        <= !i_evt.has_status;
                r_pend_status <= i_evt.status;
                r_pend_count  <= i_evt.pair_count;
            end else begin
                r_kind      <= KIND_STATUS;
                r_name_off  <= '0;
                r_value_off <= '0;
                r_status    <= i_evt.status;
                r_count     <= i_evt.pair_count;
                r_last      <= 1'b1;
            end
        end
    end

    a_pend_behind_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_valid && r_kind == KIND_PAIR && !r_last))
        else $error("pending status without a pair word in front");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_kind == KIND_STATUS) |-> r_last)
        else $error("status word not marked last");

endmodule

`default_nettype wire

[hdl/startup_message_parser.sv]
// top level of the startup message parser
//
// Bytes of a startup message enter through a queue-style port: a byte is
// taken at a clock edge with push high and full low; first marks the first
// length byte of a new message. Results leave the same way: the oldest word
// sits on the result ports while empty is low and is taken when pop is high.
// Each completed name/value pair gives a pair word; a message not cut off
// by a new first ends with one status word (last high) carrying the outcome
// and pair count. The always-ready cfg channel writes the expected version.
//
// One byte per cycle sustained while full is low. A result passes from its
// byte through the event queue into the output register; a pair closing
// the message gives two words, the pair word and then its status word.
// When pop is held low the parser keeps taking bytes until the four-entry
// event queue fills, then full rises until words are drained.
// Reset clears the parse state and all queued results, and sets the
// expected version to 0x00030000.
`default_nettype none

module startup_message_parser
    import smp_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_first,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_kind,
    output logic [11:0]      o_name_offset,
    output logic [11:0]      o_value_offset,
    output logic [2:0]       o_status,
    output logic [11:0]      o_pair_count,
    output logic             o_last
);

    logic accept;
    t_evt front_evt;
    logic front_evt_valid;
    t_evt queue_evt;
    logic queue_empty;
    logic queue_rd;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    // parser front
    smp_front #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_first     (i_first),
        .o_evt       (front_evt),
        .o_evt_valid (front_evt_valid)
    );

    // event queue
    smp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_evt_valid),
        .i_evt   (front_evt),
        .o_full  (full),
        .i_rd    (queue_rd),
        .o_evt   (queue_evt),
        .o_empty (queue_empty)
    );

    // result side
    smp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_evt          (queue_evt),
        .i_evt_empty    (queue_empty),
        .o_evt_rd       (queue_rd),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_kind         (o_kind),
        .o_name_offset  (o_name_offset),
        .o_value_offset (o_value_offset),
        .o_status       (o_status),
        .o_pair_count   (o_pair_count),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

[tb/tb.sv]
// testbench for the startup message parser: byte stimulus, predictor and result check
`timescale 1ns / 100ps

// one result word as it leaves the parser
typedef struct packed {
    logic        kind;
    logic [11:0] name_off;
    logic [11:0] value_off;
    logic [2:0]  status;
    logic [11:0] pair_count;
    logic        is_last;
} t_parser_word;

// tracks the parse of the byte stream and holds the words still due
class startup_scoreboard;
    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_HEADER, SCAN_NAME_START, SCAN_IN_NAME, SCAN_IN_VALUE, SCAN_DONE
    } t_scan_phase;

    localparam int unsigned MAX_BYTES = 4096;

    logic [31:0]  want_version;
    logic [12:0]  pos;
    logic [31:0]  msg_len;
    logic [31:0]  ver_word;
    t_scan_phase  phase;
    logic [11:0]  pairs;
    logic [11:0]  name_at;
    logic [11:0]  value_at;
    t_parser_word due_words[$];
    int           errors;

    function new();
        want_version = smp_pkg::DEFAULT_VERSION;
        pos = '0;
        msg_len = '0;
        ver_word = '0;
        phase = SCAN_IDLE;
        pairs = '0;
        name_at = '0;
        value_at = '0;
        errors = 0;
    endfunction

    function void set_version(logic [31:0] v);
        want_version = v;
    endfunction

    function int pending();
        return due_words.size();
    endfunction

    function void add_word(logic kind, logic [11:0] no, logic [11:0] vo,
                           logic [2:0] st, logic is_last);
        t_parser_word w;
        w.kind = kind;
        w.name_off = no;
        w.value_off = vo;
        w.status = st;
        w.pair_count = pairs;
        w.is_last = is_last;
        due_words.push_back(w);
    endfunction

    // status word closes the message, later bytes are ignored until first
    function void close_message(logic [2:0] st);
        add_word(smp_pkg::KIND_STATUS, '0, '0, st, 1'b1);
        phase = SCAN_DONE;
    endfunction

    // one accepted byte
    function void note_byte(logic [7:0] b, logic first);
        logic [12:0] idx;
        logic        at_end;
        if (first) begin
            phase = SCAN_HEADER;
            pos = '0;
            msg_len = '0;
            ver_word = '0;
            pairs = '0;
            name_at = '0;
            value_at = '0;
        end
        if (phase == SCAN_IDLE || phase == SCAN_DONE) return;

        // length then version, both big-endian
        if (phase == SCAN_HEADER) begin
            if (pos < 4) msg_len = {msg_len[23:0], b};
            else ver_word = {ver_word[23:0], b};
            pos = pos + 1'b1;
            if (pos < 8) return;
            if (ver_word != want_version) close_message(smp_pkg::ST_BAD_VERSION);
            else if (msg_len < 8 || msg_len > MAX_BYTES) close_message(smp_pkg::ST_BAD_LENGTH);
            else if (msg_len == 8) close_message(smp_pkg::ST_NO_TERM);
            else phase = SCAN_NAME_START;
            return;
        end

        idx = pos;
        at_end = (32'(idx) + 32'd1 == msg_len);
        pos = pos + 1'b1;

        // name/value list
        case (phase)
            SCAN_NAME_START: begin
                if (b == 8'h00) begin
                    if (!at_end) close_message(smp_pkg::ST_TRAILING);
                    else if (pairs == 0) close_message(smp_pkg::ST_NO_USER);
                    else close_message(smp_pkg::ST_OK);
                end else begin
                    name_at = idx[11:0];
                    phase = SCAN_IN_NAME;
                    if (at_end) close_message(smp_pkg::ST_NAME_UNTERM);
                end
            end
            SCAN_IN_NAME: begin
                if (b == 8'h00) begin
                    value_at = idx[11:0] + 12'd1;
                    phase = SCAN_IN_VALUE;
                    if (at_end) close_message(smp_pkg::ST_VALUE_UNTERM);
                end else if (at_end) begin
                    close_message(smp_pkg::ST_NAME_UNTERM);
                end
            end
            SCAN_IN_VALUE: begin
                if (b == 8'h00) begin
                    pairs = pairs + 12'd1;
                    add_word(smp_pkg::KIND_PAIR, name_at, value_at, smp_pkg::ST_OK, !at_end);
                    if (at_end) close_message(smp_pkg::ST_NO_TERM);
                    else phase = SCAN_NAME_START;
                end else if (at_end) begin
                    close_message(smp_pkg::ST_VALUE_UNTERM);
                end
            end
            default: phase = SCAN_DONE;
        endcase
    endfunction

    // one accepted result word against the oldest one due
    function void check_word(t_parser_word got);
        t_parser_word exp;
        if (due_words.size() == 0) begin
            $display("%0t: word with none due: kind %0d status %0d count %0d",
                     $time, got.kind, got.status, got.pair_count);
            errors++;
            return;
        end
        exp = due_words.pop_front();
        if (got.kind !== exp.kind) begin
            $display("%0t: kind expected %0d got %0d", $time, exp.kind, got.kind);
            errors++;
        end
        if (got.name_off !== exp.name_off) begin
            $display("%0t: name_offset expected %0d got %0d", $time, exp.name_off, got.name_off);
            errors++;
        end
        if (got.value_off !== exp.value_off) begin
            $display("%0t: value_offset expected %0d got %0d", $time, exp.value_off,
                     got.value_off);
            errors++;
        end
        if (got.status !== exp.status) begin
            $display("%0t: status expected %0d got %0d", $time, exp.status, got.status);
            errors++;
        end
        if (got.pair_count !== exp.pair_count) begin
            $display("%0t: pair_count expected %0d got %0d", $time, exp.pair_count,
                     got.pair_count);
            errors++;
        end
        if (got.is_last !== exp.is_last) begin
            $display("%0t: last expected %0d got %0d", $time, exp.is_last, got.is_last);
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int MAX_MESSAGE_BYTES = 4096;
    localparam int SETTLE_CYCLES     = 10;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int PHASE_BYTES       = 270;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;
    logic        push;
    logic        full;
    logic [7:0]  i_data_byte;
    logic        i_first;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_kind;
    logic [11:0] o_name_offset;
    logic [11:0] o_value_offset;
    logic [2:0]  o_status;
    logic [11:0] o_pair_count;
    logic        o_last;

    startup_scoreboard sb;
    logic [7:0]  body_q[$];
    logic [31:0] cur_version;
    int          idle_pct;
    int          stall_pct;
    int          sent_bytes;
    int          cycles = 0;

    startup_message_parser #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_data_byte    (i_data_byte),
        .i_first        (i_first),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_name_offset  (o_name_offset),
        .o_value_offset (o_value_offset),
        .o_status       (o_status),
        .o_pair_count   (o_pair_count),
        .o_last         (o_last)
    );

    // clock
    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stalls at random
    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= stall_pct);
    end

    // watch all three handshakes at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_version(i_cfg_data);
            if (push && !full) sb.note_byte(i_data_byte, i_first);
            if (pop && !empty) begin
                sb.check_word({o_kind, o_name_offset, o_value_offset, o_status,
                               o_pair_count, o_last});
            end
        end
    end

    // send one byte, entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic first);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_data_byte <= b;
        i_first <= first;
        do @(posedge i_clk); while (full);
        sent_bytes++;
        @(negedge i_clk);
    endtask

    // header then the bytes in body_q
    task automatic send_msg(input logic [31:0] len, input logic [31:0] ver);
        for (int i = 0; i < 4; i++) send_byte(len[31 - 8 * i -: 8], i == 0);
        for (int i = 0; i < 4; i++) send_byte(ver[31 - 8 * i -: 8], 1'b0);
        foreach (body_q[k]) send_byte(body_q[k], 1'b0);
    endtask

    task automatic add_pair(input int name_len, input int value_len);
        repeat (name_len) body_q.push_back(8'($urandom_range(1, 255)));
        body_q.push_back(8'h00);
        repeat (value_len) body_q.push_back(8'($urandom_range(1, 255)));
        body_q.push_back(8'h00);
    endtask

    // well-formed list of exactly target bytes, or a bare terminator below 4
    task automatic fill_body(input int target);
        int rem;
        int nl;
        int vl;
        body_q.delete();
        if (target < 4) begin
            body_q.push_back(8'h00);
            return;
        end
        rem = target;
        while (rem > 24) begin
            nl = $urandom_range(1, 8);
            vl = $urandom_range(0, 8);
            add_pair(nl, vl);
            rem -= nl + vl + 2;
        end
        add_pair(1, rem - 4);
        body_q.push_back(8'h00);
    endtask

    // mostly well-formed messages, some broken in one way
    task automatic send_random_message();
        int          m;
        int          k;
        int          sel;
        logic [31:0] len;
        logic [31:0] ver;
        sel = $urandom_range(99);
        if (sel < 8) fill_body(0);
        else if (sel < 10) fill_body($urandom_range(40, 300));
        else fill_body($urandom_range(4, 40));
        len = 8 + body_q.size();
        ver = cur_version;
        m = $urandom_range(99);
        if (m < 6) begin
            ver = ver ^ (32'd1 << $urandom_range(31));
        end else if (m < 9) begin
            ver = $urandom();
        end else if (m < 17) begin
            len = $urandom_range(8, len - 1);
        end else if (m < 23) begin
            // bytes after the terminator but inside the length
            k = $urandom_range(1, 4);
            repeat (k) body_q.push_back(8'($urandom_range(255)));
            len += k;
        end else if (m < 27) begin
            if ($urandom_range(1)) len = $urandom_range(7);
            else len = $urandom_range(MAX_MESSAGE_BYTES + 1, 32'hFFFF_FFFF);
        end else if (m < 31) begin
            // never ends, cut off by the next first
            len += $urandom_range(1, 20);
        end else if (m < 35) begin
            k = $urandom_range(body_q.size() - 1);
            while (body_q.size() > k) void'(body_q.pop_back());
        end else if (m < 40) begin
            foreach (body_q[j]) begin
                body_q[j] = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
            end
        end
        send_msg(len, ver);
        // stray bytes with first low
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    // register write only with nothing in flight
    task automatic write_version(input logic [31:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_version = v;
    endtask

    task automatic run_phase(input logic [31:0] v, input int idle, input int stall);
        int start;
        int msgs;
        write_version(v);
        idle_pct = idle;
        stall_pct = stall;
        start = sent_bytes;
        msgs = 0;
        while (sent_bytes - start < PHASE_BYTES) begin
            send_random_message();
            msgs++;
            // let the result side run dry once per phase
            if (msgs == 4) wait_drained();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_data_byte = '0;
        i_first = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        sent_bytes = 0;
        cur_version = smp_pkg::DEFAULT_VERSION;
        sb = new();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // bytes before any first are dropped
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        // one good pair
        body_q = '{8'h61, 8'h00, 8'h62, 8'h00, 8'h00};
        send_msg(32'd13, smp_pkg::DEFAULT_VERSION);
        // wrong version, body ignored after the status
        send_msg(32'd13, 32'h0003_0001);
        // length out of range on both sides, then header only
        body_q.delete();
        send_msg(32'd7, smp_pkg::DEFAULT_VERSION);
        send_msg(32'd4097, smp_pkg::DEFAULT_VERSION);
        send_msg(32'd8, smp_pkg::DEFAULT_VERSION);
        // terminator with no pairs
        body_q = '{8'h00};
        send_msg(32'd9, smp_pkg::DEFAULT_VERSION);
        // terminator before the end
        body_q = '{8'h61, 8'h00, 8'h62, 8'h00, 8'h00, 8'h58};
        send_msg(32'd14, smp_pkg::DEFAULT_VERSION);
        // ends in a name
        body_q = '{8'h61};
        send_msg(32'd9, smp_pkg::DEFAULT_VERSION);
        body_q = '{8'h61, 8'h62};
        send_msg(32'd10, smp_pkg::DEFAULT_VERSION);
        // ends after the name or inside the value
        body_q = '{8'h61, 8'h00};
        send_msg(32'd10, smp_pkg::DEFAULT_VERSION);
        body_q = '{8'h61, 8'h00, 8'h62, 8'h63};
        send_msg(32'd12, smp_pkg::DEFAULT_VERSION);
        // ends right after a value
        body_q = '{8'h61, 8'h00, 8'h62, 8'h00};
        send_msg(32'd12, smp_pkg::DEFAULT_VERSION);
        // dropped halfway by the next first
        body_q = '{8'h61, 8'h00};
        send_msg(32'd20, smp_pkg::DEFAULT_VERSION);
        // largest length passes the header, then cut off by the next first
        body_q = '{8'h61, 8'h00, 8'h62};
        send_msg(MAX_MESSAGE_BYTES, smp_pkg::DEFAULT_VERSION);

        // random phases, one register setting each
        run_phase(32'h0000_0000, 0, 0);
        run_phase(32'hFFFF_FFFF, 50, 0);
        run_phase($urandom(), 0, 50);
        run_phase(smp_pkg::DEFAULT_VERSION, 21, 21);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
